// ===== rtl/b64e_pkg.sv =====
// Shared types, constants and alphabet mapping for the line-wrapped Base64 encoder.
package b64e_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;
   localparam logic [7:0] PAD_CHAR          = 8'h3D;
   localparam logic [7:0] NEWLINE_CHAR      = 8'h0A;
   localparam logic [7:0] LINE_COUNT_MAX    = 8'hFF;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic            last;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic [7:0] sym_char(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         r = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         r = 8'h2B;
      end else begin
         r = 8'h2F;
      end
      return r;
   endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// Front end: accepts source bytes, tracks group phase and builds a group of symbols.
module b64e_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_last_byte,
   input  b64e_pkg::fifo_status_type  fifo_status,
   output logic                       push,
   output b64e_pkg::group_type        push_group
);

   logic [5:0] carry_bits_ff, carry_bits_in;
   logic [1:0] group_phase_ff, group_phase_in;
   logic [5:0] carry_next;
   logic [1:0] phase_next;
   b64e_pkg::group_type grp;

   assign req_stall = fifo_status.full;
   assign push      = req_valid && !fifo_status.full;

   always_comb begin
      grp        = '0;
      carry_next = '0;
      phase_next = b64e_pkg::PHASE_FIRST;
      case (group_phase_ff)
         b64e_pkg::PHASE_SECOND: begin
            grp.chars[0] = b64e_pkg::sym_char(carry_bits_ff | {2'b00, req_data_byte[7:4]});
            carry_next   = {req_data_byte[3:0], 2'b00};
            phase_next   = b64e_pkg::PHASE_THIRD;
            grp.last_idx = 2'd0;
            if (req_last_byte) begin
               grp.chars[1] = b64e_pkg::sym_char(carry_next);
               grp.chars[2] = b64e_pkg::PAD_CHAR;
               grp.last_idx = 2'd2;
            end
         end
         b64e_pkg::PHASE_THIRD: begin
            grp.chars[0] = b64e_pkg::sym_char(carry_bits_ff | {4'b0000, req_data_byte[7:6]});
            grp.chars[1] = b64e_pkg::sym_char(req_data_byte[5:0]);
            carry_next   = '0;
            phase_next   = b64e_pkg::PHASE_FIRST;
            grp.last_idx = 2'd1;
         end
         default: begin
            grp.chars[0] = b64e_pkg::sym_char(req_data_byte[7:2]);
            carry_next   = {req_data_byte[1:0], 4'b0000};
            phase_next   = b64e_pkg::PHASE_SECOND;
            grp.last_idx = 2'd0;
            if (req_last_byte) begin
               grp.chars[1] = b64e_pkg::sym_char(carry_next);
               grp.chars[2] = b64e_pkg::PAD_CHAR;
               grp.chars[3] = b64e_pkg::PAD_CHAR;
               grp.last_idx = 2'd3;
            end
         end
      endcase
      grp.last = req_last_byte;
   end

   assign push_group = grp;

   always_comb begin
      carry_bits_in  = carry_bits_ff;
      group_phase_in = group_phase_ff;
      if (push) begin
         carry_bits_in  = req_last_byte ? 6'd0 : carry_next;
         group_phase_in = req_last_byte ? b64e_pkg::PHASE_FIRST : phase_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_bits_ff  <= '0;
         group_phase_ff <= b64e_pkg::PHASE_FIRST;
      end else begin
         carry_bits_ff  <= carry_bits_in;
         group_phase_ff <= group_phase_in;
      end
   end

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      group_phase_ff != 2'd3)
      else $error("group phase reached unused code");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      push && req_last_byte |=> group_phase_ff == b64e_pkg::PHASE_FIRST && carry_bits_ff == 6'd0)
      else $error("state not cleared after last byte");

   a_third_no_carry: assert property (@(posedge clock) disable iff (reset)
      group_phase_ff == b64e_pkg::PHASE_FIRST |-> carry_bits_ff == 6'd0)
      else $error("carry bits left at group start");

endmodule

// ===== rtl/b64e_queue.sv =====
// Short queue of symbol groups between the front end and the output back end.
module b64e_queue #(
   parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  b64e_pkg::group_type        push_group,
   input  logic                       pop,
   output b64e_pkg::group_type        head_group,
   output b64e_pkg::fifo_status_type  status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64e_pkg::group_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_group   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_group;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

// ===== rtl/b64e_back.sv =====
// Back end: walks each symbol group, inserts newlines and holds the output register.
module b64e_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [7:0]                 csr_write_data,
   input  b64e_pkg::group_type        head_group,
   input  b64e_pkg::fifo_status_type  fifo_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_last_char
);

   logic [7:0] line_length_ff;
   logic [7:0] line_count_ff, line_count_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       last_char_ff, last_char_in;
   logic       load;
   logic       need_newline;
   logic       final_char;

   assign load         = !rsp_valid_ff || !rsp_stall;
   assign need_newline = (line_length_ff != 8'd0) && (line_count_ff >= line_length_ff);
   assign final_char   = (idx_ff == head_group.last_idx);

   always_comb begin
      line_count_in = line_count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_char_in   = out_char_ff;
      last_char_in  = last_char_ff;
      pop           = 1'b0;
      if (load) begin
         rsp_valid_in = !fifo_status.empty;
         if (!fifo_status.empty) begin
            if (need_newline) begin
               out_char_in   = b64e_pkg::NEWLINE_CHAR;
               last_char_in  = 1'b0;
               line_count_in = '0;
            end else begin
               out_char_in  = head_group.chars[idx_ff];
               last_char_in = head_group.last && final_char;
               if (head_group.last && final_char) begin
                  line_count_in = '0;
               end else if (line_count_ff != b64e_pkg::LINE_COUNT_MAX) begin
                  line_count_in = line_count_ff + 8'd1;
               end
               if (final_char) begin
                  pop    = 1'b1;
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= b64e_pkg::LINE_LENGTH_RESET;
         line_count_ff  <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            line_length_ff <= csr_write_data;
         end
         line_count_ff <= line_count_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff  <= out_char_in;
      last_char_ff <= last_char_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = out_char_ff;
   assign rsp_last_char = last_char_ff;

   a_last_clears_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_char_ff |-> line_count_ff == 8'd0 && idx_ff == 2'd0)
      else $error("line state not cleared at end of message");

   a_newline_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_char_ff == b64e_pkg::NEWLINE_CHAR |-> !last_char_ff)
      else $error("message ends on a newline");

   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      !fifo_status.empty |-> idx_ff <= head_group.last_idx)
      else $error("symbol index beyond group");

endmodule

// ===== rtl/base64_line_wrapped_encoder.sv =====
// Top level of the streaming Base64 encoder with line wrapping.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data_byte, req_last_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_out_char, rsp_last_char
//   csr      in         csr_write_enable     csr_write_data (line length)
//
// One character leaves per cycle while the output is not stalled and the queue
// is not empty; a byte yields one to four characters, each possibly led by a
// newline, so the rate at which bytes are taken in long messages is set by
// the single-character output register.
// A byte is taken in the cycle it arrives while the group queue has room.
// Reset is synchronous; line length returns to 76 and all stream control state clears.
// Output stall holds the output register; the queue absorbs input meanwhile.
module base64_line_wrapped_encoder #(
   parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char
);

   b64e_pkg::fifo_status_type fifo_status;
   b64e_pkg::group_type       push_group;
   b64e_pkg::group_type       head_group;
   logic                      push;
   logic                      pop;

   b64e_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .fifo_status   (fifo_status),
      .push          (push),
      .push_group    (push_group)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head_group (head_group),
      .status     (fifo_status)
   );

   b64e_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head_group       (head_group),
      .fifo_status      (fifo_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_char    (rsp_last_char)
   );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the line-wrapped Base64 encoder: random byte streams, random idling.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GAP_MAX       = 18;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam logic [64*8-1:0] SYMBOLS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } src_byte_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } enc_char_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data   = 8'd0;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte    = 8'd0;
   logic       req_last_byte    = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last_char;

   src_byte_type bytes_to_send[$];
   enc_char_type chars_due[$];
   int        fault_count  = 0;
   int        quiet_cycles = 0;
   int        send_gap     = 0;
   int        take_hold    = 0;
   bit        send_calm    = 1'b0;
   bit        take_calm    = 1'b0;

   // encoder state as predicted
   logic [7:0] wrap_len  = b64e_pkg::LINE_LENGTH_RESET;
   logic [5:0] carry     = 6'd0;
   logic [1:0] grp_phase = b64e_pkg::PHASE_FIRST;
   logic [7:0] line_cnt  = 8'd0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   base64_line_wrapped_encoder DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_char    (rsp_last_char)
   );

   function automatic int draw_wait(input bit calm);
      if (calm || $urandom_range(0, 1) == 0) begin
         return 0;
      end
      return $urandom_range(0, GAP_MAX);
   endfunction

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      return SYMBOLS[(63 - v) * 8 +: 8];
   endfunction

   task automatic put_char(input logic [7:0] ch, input logic fin);
      enc_char_type e;
      if (wrap_len != 8'd0 && line_cnt >= wrap_len) begin
         e.ch   = b64e_pkg::NEWLINE_CHAR;
         e.last = 1'b0;
         chars_due.push_back(e);
         line_cnt = 8'd0;
      end
      e.ch   = ch;
      e.last = fin;
      chars_due.push_back(e);
      if (line_cnt != b64e_pkg::LINE_COUNT_MAX) begin
         line_cnt = line_cnt + 8'd1;
      end
   endtask

   task automatic encode_byte(input logic [7:0] b, input logic fin);
      case (grp_phase)
         b64e_pkg::PHASE_SECOND: begin
            put_char(sextet_char(carry | {2'b00, b[7:4]}), 1'b0);
            carry     = {b[3:0], 2'b00};
            grp_phase = b64e_pkg::PHASE_THIRD;
         end
         b64e_pkg::PHASE_THIRD: begin
            put_char(sextet_char(carry | {4'b0000, b[7:6]}), 1'b0);
            put_char(sextet_char(b[5:0]), fin);
            carry     = 6'd0;
            grp_phase = b64e_pkg::PHASE_FIRST;
         end
         default: begin
            put_char(sextet_char(b[7:2]), 1'b0);
            carry     = {b[1:0], 4'b0000};
            grp_phase = b64e_pkg::PHASE_SECOND;
         end
      endcase
      if (fin) begin
         if (grp_phase == b64e_pkg::PHASE_SECOND) begin
            put_char(sextet_char(carry), 1'b0);
            put_char(b64e_pkg::PAD_CHAR, 1'b0);
            put_char(b64e_pkg::PAD_CHAR, 1'b1);
         end else if (grp_phase == b64e_pkg::PHASE_THIRD) begin
            put_char(sextet_char(carry), 1'b0);
            put_char(b64e_pkg::PAD_CHAR, 1'b1);
         end
         carry     = 6'd0;
         grp_phase = b64e_pkg::PHASE_FIRST;
         line_cnt  = 8'd0;
      end
   endtask

   always @(posedge clock) begin : drive
      logic         keep;
      src_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // hold the payload while stalled
         keep = req_valid && req_stall;
         if (!keep) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
            end else if (bytes_to_send.size() > 0) begin
               nxt = bytes_to_send.pop_front();
               req_data_byte <= nxt.data;
               req_last_byte <= nxt.last;
               send_gap = draw_wait(send_calm);
               keep = 1'b1;
            end
         end
         req_valid <= keep;
      end
   end

   always @(posedge clock) begin : watch
      enc_char_type due;
      if (reset) begin
         wrap_len  = b64e_pkg::LINE_LENGTH_RESET;
         carry     = 6'd0;
         grp_phase = b64e_pkg::PHASE_FIRST;
         line_cnt  = 8'd0;
         take_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_byte(req_data_byte, req_last_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (chars_due.size() == 0) begin
               $display("%0t ns: transfer with nothing expected, actual char %02h last %0b",
                        $time, rsp_out_char, rsp_last_char);
               fault_count++;
            end else begin
               due = chars_due.pop_front();
               if (rsp_out_char !== due.ch) begin
                  $display("%0t ns: out_char expected %02h actual %02h",
                           $time, due.ch, rsp_out_char);
                  fault_count++;
               end
               if (rsp_last_char !== due.last) begin
                  $display("%0t ns: last_char expected %0b actual %0b",
                           $time, due.last, rsp_last_char);
                  fault_count++;
               end
            end
            take_hold = draw_wait(take_calm);
         end
         if (take_hold > 0) begin
            take_hold = take_hold - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic fin);
      src_byte_type s;
      s.data = b;
      s.last = fin;
      bytes_to_send.push_back(s);
   endtask

   task automatic queue_message(input int len);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 7))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
         endcase
         queue_byte(b, i == len - 1);
      end
   endtask

   task automatic settle();
      while (bytes_to_send.size() != 0 || req_valid || chars_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_line_length(input logic [7:0] v);
      settle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      wrap_len = v;
   endtask

   initial begin : stimulus
      logic [7:0] wrap_plan [10];
      int         budget;
      int         len;
      wrap_plan = '{8'd0, 8'd255, 8'd2, 8'd3, 8'd76, 8'd5, 8'd1, 8'd64, 8'd0, 8'd0};
      wrap_plan[8] = 8'($urandom_range(1, 255));
      wrap_plan[9] = 8'($urandom_range(1, 255));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // one, two and three byte messages at the reset line length
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hFB, 1'b0);
      queue_byte(8'hEF, 1'b0);
      queue_byte(8'hBE, 1'b1);

      // newline before every character but the first of each message
      set_line_length(8'd1);
      queue_byte(8'h4D, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h6E, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h7F, 1'b1);
      queue_byte(8'h01, 1'b1);

      // break exactly at a group boundary, no trailing newline
      set_line_length(8'd4);
      queue_byte(8'h12, 1'b0);
      queue_byte(8'h34, 1'b0);
      queue_byte(8'h56, 1'b0);
      queue_byte(8'hAB, 1'b0);
      queue_byte(8'hCD, 1'b0);
      queue_byte(8'hEF, 1'b1);

      for (int k = 0; k < 10; k++) begin
         set_line_length(wrap_plan[k]);
         send_calm = (k % 3 == 0);
         take_calm = (k % 4 == 1);
         budget = 15;
         if (wrap_plan[k] == 8'd255) begin
            queue_message(195);
         end
         while (budget > 0) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
            queue_message(len);
            budget = budget - len;
         end
      end

      settle();
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== base64_line_wrapped_encoder.f =====
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_line_wrapped_encoder.sv
sim/tb.sv
